// ===== hw/rtl/bed_pkg.sv =====
// ----------------------------------------------------------------------------
// bed_pkg: shared types and constants for the button event detector
// Widths of the counters, register indexes, event codes and the structs that
// carry configuration and detector state between modules.
// ----------------------------------------------------------------------------
package bed_pkg;

    // counter widths
    localparam int TICK_W  = 16;
    localparam int COUNT_W = 8;
    localparam int WIN_W   = TICK_W + 1;

    // configuration port
    localparam int CFG_W = 16;
    localparam int IDX_W = 3;

    // result fields
    localparam int EV_W    = 3;
    localparam int TOTAL_W = 8;

    // compare width wide enough for every counter against every register
    localparam int CMP_W  = ((WIN_W > CFG_W) ? WIN_W : CFG_W) + 1;
    localparam int TOTX_W = (COUNT_W > TOTAL_W) ? COUNT_W : TOTAL_W;

    typedef enum logic [IDX_W-1:0] {
        REG_DEBOUNCE = 3'd0,
        REG_HOLD     = 3'd1,
        REG_WINDOW   = 3'd2,
        REG_ACTIVE   = 3'd3,
        REG_RUN      = 3'd4
    } t_reg_idx;

    typedef enum logic [EV_W-1:0] {
        EV_NONE    = 3'd0,
        EV_PRESS   = 3'd1,
        EV_MULTI   = 3'd2,
        EV_LONG    = 3'd3,
        EV_RELEASE = 3'd4
    } t_event;

    typedef struct packed {
        logic [CFG_W-1:0] debounce;
        logic [CFG_W-1:0] hold;
        logic [CFG_W-1:0] click_window;
        logic             active_level;
        logic             run_enable;
    } t_cfg;

    typedef struct packed {
        logic               key_down;
        logic [TICK_W-1:0]  level;
        logic [COUNT_W-1:0] clicks;
        logic [WIN_W-1:0]   window;
    } t_state;

    // Clamp the click count to the width of the result field.
    function automatic logic [TOTAL_W-1:0] sat_total(input logic [COUNT_W-1:0] clicks);
        logic [TOTX_W-1:0] wide;
        logic [TOTX_W-1:0] cap;
        wide = TOTX_W'(clicks);
        cap  = TOTX_W'({TOTAL_W{1'b1}});
        return (wide > cap) ? {TOTAL_W{1'b1}} : TOTAL_W'(wide);
    endfunction

endpackage

// ===== hw/rtl/button_event_detector.sv =====
// ----------------------------------------------------------------------------
// button_event_detector: debounced press, multi press, long press, release
// One sampled pin level in, one event item out per tick.
//
//   channel | handshake                  | payload
//   --------+----------------------------+-------------------------------
//   input   | i_in_valid  / o_in_ready   | i_pin_level
//   output  | o_out_valid / i_out_ready  | o_event_code, o_click_total
//   config  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// An item waits in the input register and moves on into the result register
// when it is free or drains: one item per cycle unless the output stalls.
// The detector state updates as an item moves into the result register.
// Reset clears valids, state and loads register defaults; config is always
// ready. A stalled output holds its item while one more item waits in the
// input register.
// ----------------------------------------------------------------------------
module button_event_detector (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_pin_level,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [bed_pkg::EV_W-1:0]    o_event_code,
    output logic [bed_pkg::TOTAL_W-1:0] o_click_total,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bed_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [bed_pkg::CFG_W-1:0]   i_cfg_data
);
    import bed_pkg::*;

    t_cfg                cfg;
    logic                cfg_clear;
    t_state              r_state;
    t_state              tick_state;
    t_event              tick_event;
    logic [TOTAL_W-1:0]  tick_total;
    logic                r_in_valid;
    logic                r_in_pin;
    logic                r_out_valid;
    t_event              r_out_event;
    logic [TOTAL_W-1:0]  r_out_total;
    logic                advance;

    assign o_cfg_ready = 1'b1;

    bed_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg),
        .o_clear    (cfg_clear)
    );

    // Move the waiting item on when the result register is free or drains.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Hold the sampled level of the next item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_pin <= i_pin_level;
        end
    end

    bed_tick_logic u_tick (
        .i_cfg         (cfg),
        .i_state       (r_state),
        .i_pin_level   (r_in_pin),
        .o_state       (tick_state),
        .o_event       (tick_event),
        .o_click_total (tick_total)
    );

    // Advance detector state per item; a run register write clears it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_clear) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= tick_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_event <= tick_event;
            r_out_total <= tick_total;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_code  = r_out_event;
    assign o_click_total = r_out_total;

    // State stays cleared while the detector is stopped.
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cfg.run_enable |-> (r_state == '0))
        else $error("detector state changed while stopped");

    // A press is always the first click, a multi press a later one.
    a_press_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_out_event == EV_PRESS)) |-> (o_click_total == TOTAL_W'(1)))
        else $error("press reported with click total other than one");

    a_multi_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_out_event == EV_MULTI)) |-> (o_click_total > TOTAL_W'(1)))
        else $error("multi press reported with click total below two");

    // A waiting item is never dropped while the output stalls.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_pin)))
        else $error("waiting input item lost");

endmodule

// ===== hw/rtl/bed_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bed_cfg_regs: configuration register file
// Holds the five control registers and flags a write to the run register,
// which clears the detector state.
// ----------------------------------------------------------------------------
module bed_cfg_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic [bed_pkg::IDX_W-1:0] i_wr_index,
    input  logic [bed_pkg::CFG_W-1:0] i_wr_data,
    output bed_pkg::t_cfg             o_cfg,
    output logic                      o_clear
);
    import bed_pkg::*;

    t_cfg r_cfg;

    // Decode the index and update the addressed register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce     <= CFG_W'(20);
            r_cfg.hold         <= CFG_W'(1000);
            r_cfg.click_window <= '0;
            r_cfg.active_level <= 1'b0;
            r_cfg.run_enable   <= 1'b0;
        end else if (i_wr_en) begin
            unique case (t_reg_idx'(i_wr_index))
                REG_DEBOUNCE: r_cfg.debounce     <= i_wr_data;
                REG_HOLD:     r_cfg.hold         <= i_wr_data;
                REG_WINDOW:   r_cfg.click_window <= i_wr_data;
                REG_ACTIVE:   r_cfg.active_level <= i_wr_data[0];
                REG_RUN:      r_cfg.run_enable   <= i_wr_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg   = r_cfg;
    assign o_clear = i_wr_en && (t_reg_idx'(i_wr_index) == REG_RUN);

endmodule

// ===== hw/rtl/bed_tick_logic.sv =====
// ----------------------------------------------------------------------------
// bed_tick_logic: per-tick next state and event
// Window aging, debounce counting, press / multi press, release and long
// press detection for one sampled pin level.
// ----------------------------------------------------------------------------
module bed_tick_logic (
    input  bed_pkg::t_cfg                  i_cfg,
    input  bed_pkg::t_state                i_state,
    input  logic                           i_pin_level,
    output bed_pkg::t_state                o_state,
    output bed_pkg::t_event                o_event,
    output logic [bed_pkg::TOTAL_W-1:0]    o_click_total
);
    import bed_pkg::*;

    t_state n_state;
    t_event n_event;
    logic   active;

    assign active = (i_pin_level == i_cfg.active_level);

    always_comb begin
        n_state = i_state;
        n_event = EV_NONE;
        if (i_cfg.run_enable) begin
            // age the click window; drop the count once the window has passed
            if (n_state.clicks != '0) begin
                if (n_state.window != '1) begin
                    n_state.window = n_state.window + WIN_W'(1);
                end
                if (CMP_W'(n_state.window) > CMP_W'(i_cfg.click_window)) begin
                    n_state.clicks = '0;
                    n_state.window = '0;
                end
            end
            if (!n_state.key_down) begin
                // accumulate pressed samples, fire press at the debounce count
                if (active) begin
                    if (CMP_W'(n_state.level) >= CMP_W'(i_cfg.debounce)) begin
                        n_state.key_down = 1'b1;
                        n_state.level    = '0;
                        if (n_state.clicks != '1) begin
                            n_state.clicks = n_state.clicks + COUNT_W'(1);
                        end
                        n_state.window = '0;
                        n_event = (n_state.clicks > COUNT_W'(1)) ? EV_MULTI : EV_PRESS;
                    end
                    if (n_state.level != '1) begin
                        n_state.level = n_state.level + TICK_W'(1);
                    end
                end
            end else begin
                // held: release on level change, long press on reaching hold
                if (!active) begin
                    n_state.key_down = 1'b0;
                    n_state.level    = '0;
                    n_event          = EV_RELEASE;
                end else if (n_state.level != '1) begin
                    n_state.level = n_state.level + TICK_W'(1);
                    if (CMP_W'(n_state.level) == CMP_W'(i_cfg.hold)) begin
                        n_event = EV_LONG;
                    end
                end
            end
        end
    end

    assign o_state       = n_state;
    assign o_event       = n_event;
    assign o_click_total = sat_total(n_state.clicks);

endmodule

// ===== test/tb_button_event_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_event_detector: self-checking bench for the button event detector
// Drives sampled pin levels through the valid/ready input channel, predicts
// each event item with a cycle-free model of the detector and compares every
// result item in order. Covers directed corner cases, randomized press and
// release gestures under several register settings and click count
// saturation.
// ----------------------------------------------------------------------------
module tb_button_event_detector;
    import bed_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int RAND_TICKS   = 300;

    typedef struct packed {
        t_event             code;
        logic [TOTAL_W-1:0] total;
    } t_tick_result;

    // Detector model with its own registers and state, plus the queue of
    // event items still owed by the block.
    class event_tracker;
        logic [CFG_W-1:0]   debounce;
        logic [CFG_W-1:0]   hold;
        logic [CFG_W-1:0]   click_window;
        logic               active_lvl;
        logic               run_on;
        logic               held;
        logic [TICK_W-1:0]  level;
        logic [COUNT_W-1:0] clicks;
        logic [WIN_W-1:0]   window;
        t_tick_result       due_events[$];
        int                 errors;
        int                 checked;
        int                 long_seen;

        function new();
            debounce     = 16'd20;
            hold         = 16'd1000;
            click_window = '0;
            active_lvl   = 1'b0;
            run_on       = 1'b0;
            clear_state();
            errors       = 0;
            checked      = 0;
            long_seen    = 0;
        endfunction

        function void clear_state();
            held   = 1'b0;
            level  = '0;
            clicks = '0;
            window = '0;
        endfunction

        // Apply one register write; indexes past the last register are dropped.
        function void take_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_DEBOUNCE: debounce = data;
                REG_HOLD:     hold = data;
                REG_WINDOW:   click_window = data;
                REG_ACTIVE:   active_lvl = data[0];
                REG_RUN: begin
                    run_on = data[0];
                    clear_state();
                end
                default: ;
            endcase
        endfunction

        // Advance the model by one accepted tick and queue its event item.
        function void take_tick(logic lvl);
            t_tick_result      res;
            logic              pressed;
            logic [TICK_W-1:0] prior;
            res.code = EV_NONE;
            pressed  = (lvl == active_lvl);
            if (run_on) begin
                // age the click window while clicks are counted
                if (clicks != '0) begin
                    if (window != '1) window = window + 1'b1;
                    if (window > WIN_W'(click_window)) begin
                        clicks = '0;
                        window = '0;
                    end
                end
                if (!held) begin
                    if (pressed) begin
                        if (level >= debounce) begin
                            held   = 1'b1;
                            level  = '0;
                            if (clicks != '1) clicks = clicks + 1'b1;
                            window = '0;
                            res.code = (clicks > 1) ? EV_MULTI : EV_PRESS;
                        end
                        if (level != '1) level = level + 1'b1;
                    end
                end else begin
                    prior = level;
                    if (level != '1) level = level + 1'b1;
                    if (!pressed) begin
                        held     = 1'b0;
                        level    = '0;
                        res.code = EV_RELEASE;
                    end else if (level != prior && level == hold) begin
                        res.code = EV_LONG;
                    end
                end
            end
            res.total = TOTAL_W'(clicks);
            due_events.push_back(res);
        endfunction

        // Compare one result item against the oldest prediction.
        function void check_event(logic [EV_W-1:0] code, logic [TOTAL_W-1:0] total);
            t_tick_result want;
            checked++;
            if (due_events.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected event item code=%0d total=%0d", code, total);
                return;
            end
            want = due_events.pop_front();
            if (want.code == EV_LONG) long_seen++;
            if (code !== want.code || total !== want.total) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: item %0d expected code=%0d total=%0d, got code=%0d total=%0d",
                             checked, want.code, want.total, code, total);
            end
        endfunction

        function int outstanding();
            return due_events.size();
        endfunction
    endclass

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic                o_in_ready;
    logic                i_pin_level   = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready   = 1'b0;
    logic [EV_W-1:0]     o_event_code;
    logic [TOTAL_W-1:0]  o_click_total;
    logic                i_cfg_valid   = 1'b0;
    logic                o_cfg_ready;
    logic [IDX_W-1:0]    i_cfg_index   = '0;
    logic [CFG_W-1:0]    i_cfg_data    = '0;

    event_tracker tracker = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int ticks_sent    = 0;
    int phases        = 0;
    int cycle_count   = 0;

    button_event_detector dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_pin_level  (i_pin_level),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_event_code (o_event_code),
        .o_click_total(o_click_total),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Check result items and stall the output at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.check_event(o_event_code, o_click_total);
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d items outstanding",
                     cycle_count, tracker.outstanding());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one pin sample and hold it until accepted.
    task automatic send_tick(input logic lvl);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_pin_level <= lvl;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.take_tick(lvl);
        ticks_sent++;
    endtask

    // Send the low n bits of a pattern, oldest bit first.
    task automatic send_pattern(input logic [31:0] bits, input int n);
        for (int k = n - 1; k >= 0; k--) send_tick(bits[k]);
    endtask

    // Drop the input, drain every owed item, then let the pipe settle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Write one register; valid stays up for a following write.
    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.take_write(idx, data);
    endtask

    task automatic cfg_release();
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_all(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] hld,
                           input logic [CFG_W-1:0] win, input logic act);
        cfg_write(REG_DEBOUNCE, deb);
        cfg_write(REG_HOLD, hld);
        cfg_write(REG_WINDOW, win);
        cfg_write(REG_ACTIVE, {15'($urandom), act});
        cfg_write(REG_RUN, {15'($urandom), 1'b1});
        cfg_release();
    endtask

    // Pick a random setting, mostly small counts with the extremes now and then.
    task automatic pick_setting();
        logic [CFG_W-1:0] v;
        int               pick;
        if ($urandom_range(99) < 70) begin
            pick = $urandom_range(15);
            v = (pick == 0) ? '0 : (pick == 1) ? '1 : CFG_W'($urandom_range(6));
            cfg_write(REG_DEBOUNCE, v);
        end
        if ($urandom_range(99) < 70) begin
            pick = $urandom_range(15);
            v = (pick == 0) ? '0 : (pick == 1) ? '1 : CFG_W'($urandom_range(12, 1));
            cfg_write(REG_HOLD, v);
        end
        if ($urandom_range(99) < 70) begin
            pick = $urandom_range(15);
            v = (pick == 0) ? '0 : (pick == 1) ? '1 : CFG_W'($urandom_range(25));
            cfg_write(REG_WINDOW, v);
        end
        if ($urandom_range(99) < 70) cfg_write(REG_ACTIVE, CFG_W'($urandom));
        if ($urandom_range(99) < 70) begin
            v    = CFG_W'($urandom);
            v[0] = ($urandom_range(9) != 0);
            cfg_write(REG_RUN, v);
        end
        if ($urandom_range(99) < 20)
            cfg_write(IDX_W'($urandom_range(7, 5)), CFG_W'($urandom));
        cfg_release();
    endtask

    // One gesture: a gap, a debounced press held a while, a release.
    // Some gestures are plain noise to break the sequence.
    task automatic play_gesture();
        logic act;
        int   deb;
        int   hld;
        int   win;
        int   n;
        act = tracker.active_lvl;
        deb = (tracker.debounce > 12) ? 12 : int'(tracker.debounce);
        hld = (tracker.hold > 16) ? 16 : int'(tracker.hold);
        win = (tracker.click_window > 28) ? 30 : int'(tracker.click_window) + 2;
        if ($urandom_range(99) < 20) begin
            n = $urandom_range(8, 1);
            repeat (n) send_tick(1'($urandom_range(1)));
        end else begin
            n = $urandom_range(win);
            repeat (n) send_tick(~act);
            n = deb + 1 + $urandom_range(hld + 3);
            repeat (n) send_tick(act);
            send_tick(~act);
        end
    endtask

    initial begin
        int start;
        int target;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // disabled after reset: no events
        send_pattern(32'b10, 2);
        wait_idle();

        // press, long press, release, multi press, window expiry
        set_all(16'd0, 16'd2, 16'd4, 1'b1);
        cfg_write(IDX_W'(5), 16'hA5A5);
        cfg_release();
        send_pattern(32'b111_0_1_0_0000_0_1, 11);
        wait_idle();

        // active low, released samples keep the count, zero hold count
        set_all(16'd3, 16'd0, 16'd0, 1'b0);
        send_pattern(32'b01010_0_000_1, 10);
        wait_idle();

        // largest debounce: pressed samples never reach it
        set_all(16'hFFFF, 16'd1, 16'hFFFF, 1'b1);
        send_pattern(32'b111, 3);
        wait_idle();

        // random phases: sender idles lightly, then receiver lightly, then neither
        start = ticks_sent;
        while (ticks_sent - start < RAND_TICKS) begin
            if (ticks_sent - start < RAND_TICKS / 3) begin
                send_idle_pct = 10;
                recv_idle_pct = 56;
            end else if (ticks_sent - start < 2 * RAND_TICKS / 3) begin
                send_idle_pct = 56;
                recv_idle_pct = 10;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_idle();
            pick_setting();
            phases++;
            target = ticks_sent + $urandom_range(80, 30);
            while (ticks_sent < target) play_gesture();
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // click count saturation inside the widest window
        wait_idle();
        set_all(16'd0, 16'd1, 16'hFFFF, 1'($urandom_range(1)));
        repeat (260) begin
            send_tick(tracker.active_lvl);
            send_tick(~tracker.active_lvl);
        end

        wait_idle();
        repeat (4) @(posedge i_clk);
        $display("checked %0d event items over %0d random phases, %0d long presses",
                 tracker.checked, phases, tracker.long_seen);
        $display("covered disabled ticks, debounce and hold extremes, click count cap");
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d items outstanding",
                     tracker.errors, tracker.outstanding());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/bed_pkg.sv
hw/rtl/bed_cfg_regs.sv
hw/rtl/bed_tick_logic.sv
hw/rtl/button_event_detector.sv
test/tb_button_event_detector.sv
